// ===== design/assert_macros.svh =====
// Assertion macros used by the RTL.
// Needs signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== design/spr_pkg.sv =====
// Shared types and constants of the shape pixel rasterizer.
// No dependencies.
package spr_pkg;

    localparam int DEF_MAX_FRAME_SIDE = 4096;
    localparam int DEF_COORD_BITS     = 16;

    localparam int FIELD_W = 16;   // coordinate fields of a command item
    localparam int CFG_W   = 13;   // widest configuration register
    localparam int INDEX_W = 24;   // linear pixel index
    localparam int COLOR_W = 32;
    localparam int MATH_W  = 32;   // coordinate arithmetic wraps at this width

    // item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    // shape codes
    localparam logic [1:0] SHAPE_OUTLINE = 2'd0;
    localparam logic [1:0] SHAPE_FILLED  = 2'd1;
    localparam logic [1:0] SHAPE_ROUNDED = 2'd2;
    localparam logic [1:0] SHAPE_ARROW   = 2'd3;

    // configuration register indexes
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [1:0]         shape;
        logic [FIELD_W-1:0] origin_x;
        logic [FIELD_W-1:0] origin_y;
        logic [FIELD_W-1:0] shape_width;
        logic [FIELD_W-1:0] shape_height;
        logic [FIELD_W-1:0] corner_radius;
        logic [COLOR_W-1:0] draw_color;
    } cmd_t;

    typedef struct packed {
        logic [INDEX_W-1:0] pixel_index;
        logic [COLOR_W-1:0] pixel_color;
        logic               write_enable;
        logic               final_pixel;
    } pix_t;

    // candidate handed from the walker to the index stage
    typedef struct packed {
        logic [INDEX_W-1:0] px;
        logic [INDEX_W-1:0] py;
        logic [COLOR_W-1:0] color;
        logic               write_enable;
        logic               final_pixel;
    } cand_t;

endpackage

// ===== design/shape_pixel_rasterizer.sv =====
// A result passes the stage 1 and output registers. Throughput: one item per
// cycle unless pix_ready stalls; the walker state advances in the accept cycle,
// the index multiply (row times frame width) sits in the second stage.
// Reset (rst_n, async, active low): no command loaded, frame size 0,
// pipeline empty. Every accepted item gives exactly one result item.
// Depends on spr_pkg, spr_walk and assert_macros.svh.
`include "assert_macros.svh"

module shape_pixel_rasterizer #(
    parameter int MAX_FRAME_SIDE = spr_pkg::DEF_MAX_FRAME_SIDE,
    parameter int COORD_BITS     = spr_pkg::DEF_COORD_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // command items
    input  logic                      cmd_valid,
    output logic                      cmd_ready,
    input  spr_pkg::cmd_t             cmd,
    // pixel result items
    output logic                      pix_valid,
    input  logic                      pix_ready,
    output spr_pkg::pix_t             pix,
    // configuration writes
    input  logic                      cfg_wen,
    input  logic                      cfg_index,
    input  logic [spr_pkg::CFG_W-1:0] cfg_data
);

    // frame size register width follows the largest allowed side
    localparam int FW_W = $clog2(MAX_FRAME_SIDE + 1);
    localparam int IW   = spr_pkg::INDEX_W;

    // ---------------- configuration ----------------
    logic [FW_W-1:0] frame_width_reg;
    logic [FW_W-1:0] frame_height_reg;
    logic [FW_W-1:0] cfg_sat;

    // writes above the largest side clamp to it
    assign cfg_sat = (32'(cfg_data) > 32'(MAX_FRAME_SIDE)) ? FW_W'(MAX_FRAME_SIDE)
                                                          : FW_W'(cfg_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= '0;
            frame_height_reg <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                spr_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_sat;
                spr_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_sat;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // stage 1 holds the clipped candidate, stage 2 is the output register.
    logic s1_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic s1_free;
    logic take;

    assign out_free  = !out_valid_reg || pix_ready;
    assign s1_free   = !s1_valid_reg || out_free;
    assign cmd_ready = s1_free;
    assign take      = cmd_valid && cmd_ready;
    assign pix_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
                s1_valid_reg <= take;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // ---------------- stage 1: shape walker ----------------
    spr_pkg::cand_t cand;
    spr_pkg::cand_t s1_cand_reg;
    logic           walk_busy;

    spr_walk #(
        .COORD_BITS (COORD_BITS),
        .FW_W       (FW_W)
    ) u_walk (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .cmd          (cmd),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .cand         (cand),
        .busy         (walk_busy)
    );

    always_ff @(posedge clk)
    begin
        if (take)
            s1_cand_reg <= cand;
    end

    // ---------------- stage 2: linear index ----------------
    logic [IW+FW_W-1:0] row_base;
    spr_pkg::pix_t      pix_next;
    spr_pkg::pix_t      pix_reg;

    // only the low index bits of the row matter, the index wraps at 2^24
    assign row_base = {{FW_W{1'b0}}, s1_cand_reg.py} * {{IW{1'b0}}, frame_width_reg};

    always_comb
    begin
        pix_next.write_enable = s1_cand_reg.write_enable;
        pix_next.final_pixel  = s1_cand_reg.final_pixel;
        // a non-writing result carries zero index and color
        if (s1_cand_reg.write_enable)
        begin
            pix_next.pixel_index = row_base[IW-1:0] + s1_cand_reg.px;
            pix_next.pixel_color = s1_cand_reg.color;
        end
        else
        begin
            pix_next.pixel_index = '0;
            pix_next.pixel_color = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg)
            pix_reg <= pix_next;
    end

    assign pix = pix_reg;

    // ---------------- assertions ----------------
    // a step with no command loaded ends at once and writes nothing
    `ASSERT_NEXT(a_idle_step_final,
        take && cmd.kind == spr_pkg::KIND_STEP && !walk_busy,
        s1_valid_reg && s1_cand_reg.final_pixel && !s1_cand_reg.write_enable)
    // a start item never writes a pixel
    `ASSERT_NEXT(a_start_no_write,
        take && cmd.kind == spr_pkg::KIND_START,
        s1_valid_reg && !s1_cand_reg.write_enable)
    // a non-writing result carries zero payload
    `ASSERT_IMP(a_nowrite_zero,
        pix_valid && !pix.write_enable,
        pix.pixel_index == '0 && pix.pixel_color == '0)

endmodule

// ===== design/spr_walk.sv =====
// Shape walker: command state, loop counters, candidate pixel and clipping.
// Depends on spr_pkg.
module spr_walk #(
    parameter int COORD_BITS = spr_pkg::DEF_COORD_BITS,
    parameter int FW_W       = 13
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  spr_pkg::cmd_t        cmd,
    input  logic [FW_W-1:0]      frame_width,
    input  logic [FW_W-1:0]      frame_height,
    output spr_pkg::cand_t       cand,
    output logic                 busy
);

    localparam int CW = COORD_BITS;
    localparam int MW = spr_pkg::MATH_W;

    logic          busy_reg,  busy_next;
    logic [1:0]    shape_reg, shape_next;
    logic [CW-1:0] bx_reg,    bx_next;
    logic [CW-1:0] by_reg,    by_next;
    logic [CW-1:0] ew_reg,    ew_next;
    logic [CW-1:0] eh_reg,    eh_next;
    logic [CW-1:0] rad_reg,   rad_next;
    logic [spr_pkg::COLOR_W-1:0] color_reg, color_next;
    logic [CW-1:0] outer_reg, outer_next;
    logic [CW-1:0] inner_reg, inner_next;
    logic          phase_reg, phase_next;
    logic          half_reg,  half_next;

    // 32-bit views of the state, as the arithmetic wraps there
    logic [MW-1:0] bx, by, w, h, r, row, col, ph;
    logic [MW-1:0] px, py;
    logic          in_box, side, cut, skip, do_step;

    assign bx  = MW'(bx_reg);
    assign by  = MW'(by_reg);
    assign w   = MW'(ew_reg);
    assign h   = MW'(eh_reg);
    assign r   = MW'(rad_reg);
    assign row = MW'(outer_reg);
    assign col = MW'(inner_reg);
    assign ph  = MW'(half_reg);

    // square-cut corner test of the rounded shape
    always_comb
    begin
        in_box = (row < r && col < r) || (row < r && col >= w - r) ||
                 (row >= h - r && col < r) || (row >= h - r && col >= w - r);
        side   = (col < r - 1) || (col >= w - r + 1);
        cut    = (row < r - 1 && side) || (row >= h - r + 1 && side);
    end

    always_comb
    begin
        busy_next  = busy_reg;
        shape_next = shape_reg;
        bx_next    = bx_reg;
        by_next    = by_reg;
        ew_next    = ew_reg;
        eh_next    = eh_reg;
        rad_next   = rad_reg;
        color_next = color_reg;
        outer_next = outer_reg;
        inner_next = inner_reg;
        phase_next = phase_reg;
        half_next  = half_reg;
        px         = '0;
        py         = '0;
        skip       = 1'b0;
        do_step    = 1'b0;

        if (take)
        begin
            if (cmd.kind == spr_pkg::KIND_START)
            begin
                shape_next = cmd.shape;
                bx_next    = CW'(cmd.origin_x);
                by_next    = CW'(cmd.origin_y);
                ew_next    = CW'(cmd.shape_width);
                eh_next    = CW'(cmd.shape_height);
                rad_next   = CW'(cmd.corner_radius);
                color_next = cmd.draw_color;
                outer_next = '0;
                inner_next = '0;
                phase_next = 1'b0;
                half_next  = 1'b0;
                busy_next  = 1'b1;
            end
            else if (busy_reg)
            begin
                do_step = 1'b1;
                case (shape_reg)
                    spr_pkg::SHAPE_OUTLINE:
                    begin
                        if (!phase_reg)
                        begin
                            px = bx + row;
                            py = half_reg ? by + h - 1 : by;
                        end
                        else
                        begin
                            py = by + row;
                            px = half_reg ? bx + w - 1 : bx;
                        end
                        half_next = ~half_reg;
                        if (half_reg)
                            outer_next = outer_reg + 1'b1;
                    end
                    spr_pkg::SHAPE_ARROW:
                    begin
                        py = by + row;
                        if (row < (w >> 1))
                            px = bx + row + ph;
                        else
                            px = bx + (w - 1 - row) + ph;
                        half_next = ~half_reg;
                        if (half_reg)
                            outer_next = outer_reg + 1'b1;
                    end
                    default:
                    begin
                        px = bx + col;
                        py = by + row;
                        skip = (shape_reg == spr_pkg::SHAPE_ROUNDED) && in_box && cut;
                        inner_next = inner_reg + 1'b1;
                    end
                endcase
            end
        end

        // move past exhausted loops
        if (take && busy_next)
        begin
            case (shape_next)
                spr_pkg::SHAPE_OUTLINE:
                begin
                    if (!phase_next && outer_next >= ew_next)
                    begin
                        phase_next = 1'b1;
                        outer_next = '0;
                        half_next  = 1'b0;
                    end
                    if (phase_next && outer_next >= eh_next)
                        busy_next = 1'b0;
                end
                spr_pkg::SHAPE_ARROW:
                begin
                    if (outer_next >= ew_next)
                        busy_next = 1'b0;
                end
                default:
                begin
                    if (ew_next == '0)
                        busy_next = 1'b0;
                    else
                    begin
                        if (inner_next >= ew_next)
                        begin
                            inner_next = '0;
                            outer_next = outer_next + 1'b1;
                        end
                        if (outer_next >= eh_next)
                            busy_next = 1'b0;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        cand.px           = px[spr_pkg::INDEX_W-1:0];
        cand.py           = py[spr_pkg::INDEX_W-1:0];
        cand.color        = color_reg;
        cand.write_enable = do_step && !skip &&
                            px < MW'(frame_width) && py < MW'(frame_height);
        cand.final_pixel  = !busy_next;
    end

    assign busy = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            shape_reg <= '0;
            bx_reg    <= '0;
            by_reg    <= '0;
            ew_reg    <= '0;
            eh_reg    <= '0;
            rad_reg   <= '0;
            color_reg <= '0;
            outer_reg <= '0;
            inner_reg <= '0;
            phase_reg <= 1'b0;
            half_reg  <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            shape_reg <= shape_next;
            bx_reg    <= bx_next;
            by_reg    <= by_next;
            ew_reg    <= ew_next;
            eh_reg    <= eh_next;
            rad_reg   <= rad_next;
            color_reg <= color_next;
            outer_reg <= outer_next;
            inner_reg <= inner_next;
            phase_reg <= phase_next;
            half_reg  <= half_next;
        end
    end

endmodule

// ===== sim/tb.sv =====
// Testbench for shape_pixel_rasterizer: directed shapes, frame limits and random traffic,
// checked item by item against a predictor of the pixel walk.
// Depends on spr_pkg and the shape_pixel_rasterizer RTL.
`timescale 1ns / 1ps

module tb;

    // Watchdog limit, set well above the longest run.
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 6;   // two-stage pipeline plus margin

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cmd_valid = 1'b0;
    logic                       cmd_ready;
    spr_pkg::cmd_t              cmd = '0;
    logic                       pix_valid;
    logic                       pix_ready = 1'b0;
    spr_pkg::pix_t              pix;
    logic                       cfg_wen = 1'b0;
    logic                       cfg_index = spr_pkg::REG_FRAME_WIDTH;
    logic [spr_pkg::CFG_W-1:0]  cfg_data = '0;

    shape_pixel_rasterizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: frame size and the walker of the current command.
    // All coordinate math is 32-bit unsigned so sums like y+h-1 wrap.
    // ------------------------------------------------------------------
    int unsigned fb_width;
    int unsigned fb_height;
    bit          walk_busy;
    logic [1:0]  walk_shape;
    int unsigned org_x, org_y, ext_w, ext_h, rad;
    logic [spr_pkg::COLOR_W-1:0] walk_color;
    int unsigned row_idx;       // loop index of outline / arrow, row of fill
    int unsigned col_idx;       // column of fill
    bit          vert_edges;    // outline: 0 top/bottom edges, 1 left/right edges
    bit          second_half;   // which pixel of a pair comes next

    spr_pkg::pix_t expected_pixels[$];   // results still owed by the block, oldest first

    int fail_count = 0;
    int items_sent;
    int cycle_count = 0;
    int sender_idle_pct;
    int recv_stall_pct;

    function automatic int unsigned frame_side(logic [spr_pkg::CFG_W-1:0] data);
        int unsigned v;
        v = 32'(data);
        if (v > spr_pkg::DEF_MAX_FRAME_SIDE)
            v = spr_pkg::DEF_MAX_FRAME_SIDE;
        return v;
    endfunction

    // Step past loops that are already exhausted; drop busy when nothing is left.
    function automatic void skip_done_loops();
        if (!walk_busy)
            return;
        if (walk_shape == spr_pkg::SHAPE_OUTLINE)
        begin
            if (!vert_edges && row_idx >= ext_w)
            begin
                vert_edges = 1'b1;
                row_idx = 0;
                second_half = 1'b0;
            end
            if (vert_edges && row_idx >= ext_h)
                walk_busy = 1'b0;
        end
        else if (walk_shape == spr_pkg::SHAPE_ARROW)
        begin
            if (row_idx >= ext_w)
                walk_busy = 1'b0;
        end
        else
        begin
            if (ext_w == 0)
            begin
                walk_busy = 1'b0;
                return;
            end
            if (col_idx >= ext_w)
            begin
                col_idx = 0;
                row_idx++;
            end
            if (row_idx >= ext_h)
                walk_busy = 1'b0;
        end
    endfunction

    // Rounded shape: pixel lies in a corner box and outside the cut line.
    function automatic bit corner_cut(int unsigned row, int unsigned col);
        bit in_box;
        bit side;
        bit cut;
        in_box = (row < rad && col < rad) || (row < rad && col >= ext_w - rad) ||
                 (row >= ext_h - rad && col < rad) ||
                 (row >= ext_h - rad && col >= ext_w - rad);
        side = (col < rad - 1) || (col >= ext_w - rad + 1);
        cut = (row < rad - 1 && side) || (row >= ext_h - rad + 1 && side);
        return in_box && cut;
    endfunction

    // Expected result of one accepted item; advances the walker.
    function automatic spr_pkg::pix_t rasterize(spr_pkg::cmd_t c);
        int unsigned px;
        int unsigned py;
        bit skip;
        spr_pkg::pix_t p;
        px = 0;
        py = 0;
        skip = 1'b0;
        p = '0;
        if (c.kind == spr_pkg::KIND_START)
        begin
            walk_shape = c.shape;
            org_x = 32'(c.origin_x);
            org_y = 32'(c.origin_y);
            ext_w = 32'(c.shape_width);
            ext_h = 32'(c.shape_height);
            rad = 32'(c.corner_radius);
            walk_color = c.draw_color;
            row_idx = 0;
            col_idx = 0;
            vert_edges = 1'b0;
            second_half = 1'b0;
            walk_busy = 1'b1;
            skip_done_loops();
            p.final_pixel = !walk_busy;
            return p;
        end
        if (!walk_busy)
        begin
            p.final_pixel = 1'b1;
            return p;
        end
        case (walk_shape)
            spr_pkg::SHAPE_OUTLINE:
            begin
                if (!vert_edges)
                begin
                    px = org_x + row_idx;
                    py = second_half ? org_y + ext_h - 1 : org_y;
                end
                else
                begin
                    py = org_y + row_idx;
                    px = second_half ? org_x + ext_w - 1 : org_x;
                end
                if (second_half)
                    row_idx++;
                second_half = !second_half;
            end
            spr_pkg::SHAPE_ARROW:
            begin
                py = org_y + row_idx;
                if (row_idx < ext_w / 2)
                    px = org_x + row_idx + 32'(second_half);
                else
                    px = org_x + (ext_w - 1 - row_idx) + 32'(second_half);
                if (second_half)
                    row_idx++;
                second_half = !second_half;
            end
            default:
            begin
                px = org_x + col_idx;
                py = org_y + row_idx;
                if (walk_shape == spr_pkg::SHAPE_ROUNDED)
                    skip = corner_cut(row_idx, col_idx);
                col_idx++;
            end
        endcase
        if (!skip && px < fb_width && py < fb_height)
        begin
            p.pixel_index = spr_pkg::INDEX_W'(py * fb_width + px);
            p.pixel_color = walk_color;
            p.write_enable = 1'b1;
        end
        skip_done_loops();
        p.final_pixel = !walk_busy;
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Command side. Valid is left high after acceptance; the next item
    // either follows at once or idle cycles lower it first.
    // ------------------------------------------------------------------
    task automatic send_item(input spr_pkg::cmd_t c);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        do
            @(posedge clk);
        while (!cmd_ready);
        expected_pixels.push_back(rasterize(c));
        items_sent++;
    endtask

    // Stop sending, wait for every owed result, then let the pipeline settle.
    task automatic wait_drain();
        cmd_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes both frame registers on consecutive edges; block must be idle.
    task automatic set_frame(input logic [spr_pkg::CFG_W-1:0] w,
                             input logic [spr_pkg::CFG_W-1:0] h);
        cfg_wen <= 1'b1;
        cfg_index <= spr_pkg::REG_FRAME_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        cfg_index <= spr_pkg::REG_FRAME_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        cfg_wen <= 1'b0;
        fb_width = frame_side(w);
        fb_height = frame_side(h);
    endtask

    function automatic spr_pkg::cmd_t random_any();
        spr_pkg::cmd_t c;
        c.kind = 1'($urandom_range(1));
        c.shape = 2'($urandom_range(3));
        c.origin_x = 16'($urandom);
        c.origin_y = 16'($urandom);
        c.shape_width = 16'($urandom);
        c.shape_height = 16'($urandom);
        c.corner_radius = 16'($urandom);
        c.draw_color = $urandom;
        return c;
    endfunction

    // Step items carry random payload; only kind matters.
    function automatic spr_pkg::cmd_t random_step();
        spr_pkg::cmd_t c;
        c = random_any();
        c.kind = spr_pkg::KIND_STEP;
        return c;
    endfunction

    // Mostly inside or just past the frame; some straddle the edge or wrap.
    function automatic logic [spr_pkg::FIELD_W-1:0] random_origin(int unsigned side);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return spr_pkg::FIELD_W'($urandom);
        if (roll < 22)
            return spr_pkg::FIELD_W'(side - $urandom_range(0, 4));
        return spr_pkg::FIELD_W'($urandom_range(0, side + 3));
    endfunction

    task automatic start_shape(input logic [1:0] shape, input int unsigned x,
                               input int unsigned y, input int unsigned w,
                               input int unsigned h, input int unsigned r,
                               input logic [spr_pkg::COLOR_W-1:0] color);
        spr_pkg::cmd_t c;
        c = random_any();
        c.kind = spr_pkg::KIND_START;
        c.shape = shape;
        c.origin_x = spr_pkg::FIELD_W'(x);
        c.origin_y = spr_pkg::FIELD_W'(y);
        c.shape_width = spr_pkg::FIELD_W'(w);
        c.shape_height = spr_pkg::FIELD_W'(h);
        c.corner_radius = spr_pkg::FIELD_W'(r);
        c.draw_color = color;
        send_item(c);
    endtask

    task automatic run_to_end();
        while (walk_busy)
            send_item(random_step());
    endtask

    // Well-formed command with small extents, walked to the end; sometimes cut
    // short by the next start, sometimes followed by idle steps.
    task automatic draw_random_shape();
        spr_pkg::cmd_t c;
        int abort_at;
        int k;
        c = random_any();
        c.kind = spr_pkg::KIND_START;
        c.origin_x = random_origin(fb_width);
        c.origin_y = random_origin(fb_height);
        c.shape_width = ($urandom_range(9) == 0) ? 16'($urandom_range(0, 16))
                                                 : 16'($urandom_range(0, 6));
        c.shape_height = ($urandom_range(9) == 0) ? 16'($urandom_range(0, 16))
                                                  : 16'($urandom_range(0, 6));
        c.corner_radius = ($urandom_range(19) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 4));
        send_item(c);
        abort_at = ($urandom_range(9) == 0) ? int'($urandom_range(0, 3)) : -1;
        k = 0;
        while (walk_busy && k != abort_at)
        begin
            send_item(random_step());
            k++;
        end
        if ($urandom_range(4) == 0)
            repeat ($urandom_range(1, 2)) send_item(random_step());
    endtask

    // ------------------------------------------------------------------
    // Result side: check every accepted pixel item, stall at random.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        spr_pkg::pix_t want;
        if (rst_n && pix_valid && pix_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("pixel item with none owed: index %0d", pix.pixel_index);
                fail_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (pix.pixel_index !== want.pixel_index)
                begin
                    $error("pixel_index: expected %0d, got %0d",
                           want.pixel_index, pix.pixel_index);
                    fail_count++;
                end
                if (pix.pixel_color !== want.pixel_color)
                begin
                    $error("pixel_color: expected %h, got %h",
                           want.pixel_color, pix.pixel_color);
                    fail_count++;
                end
                if (pix.write_enable !== want.write_enable)
                begin
                    $error("write_enable: expected %b, got %b",
                           want.write_enable, pix.write_enable);
                    fail_count++;
                end
                if (pix.final_pixel !== want.final_pixel)
                begin
                    $error("final_pixel: expected %b, got %b",
                           want.final_pixel, pix.final_pixel);
                    fail_count++;
                end
            end
        end
        pix_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("shape_pixel_rasterizer test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Frame is 0x0 out of reset: idle step is final, nothing ever writes.
    task automatic test_reset_state();
        send_item(random_step());
        start_shape(spr_pkg::SHAPE_FILLED, 0, 0, 2, 2, 0, 32'h1234_5678);
        run_to_end();
    endtask

    // Oversized writes saturate to 4096; a zero frame clips everything.
    task automatic test_frame_limits();
        wait_drain();
        set_frame(13'h1FFF, 13'd4097);
        start_shape(spr_pkg::SHAPE_FILLED, 4095, 4095, 2, 2, 0, 32'hA5A5_5A5A);
        run_to_end();
        wait_drain();
        set_frame(13'd0, 13'd0);
        start_shape(spr_pkg::SHAPE_OUTLINE, 0, 0, 1, 1, 0, 32'hFFFF_FFFF);
        run_to_end();
    endtask

    task automatic test_directed_shapes();
        wait_drain();
        set_frame(13'd8, 13'd6);
        // empty outline is done at the start item
        start_shape(spr_pkg::SHAPE_OUTLINE, 0, 0, 0, 0, 0, 32'h0000_0001);
        // 1x1 outline: all four candidates hit the same pixel, duplicates kept
        start_shape(spr_pkg::SHAPE_OUTLINE, 7, 5, 1, 1, 0, 32'h0F0F_0F0F);
        run_to_end();
        // fill clipped at the right edge, all-ones color
        start_shape(spr_pkg::SHAPE_FILLED, 7, 0, 2, 1, 0, 32'hFFFF_FFFF);
        run_to_end();
        // rounded corners that are skipped still use a step
        start_shape(spr_pkg::SHAPE_ROUNDED, 0, 0, 3, 3, 2, 32'h8000_0000);
        run_to_end();
        // arrow: rising half and falling half, zero color
        start_shape(spr_pkg::SHAPE_ARROW, 1, 1, 2, 0, 0, 32'h0000_0000);
        run_to_end();
        // zero height: bottom edge row wraps to y-1 and is clipped
        start_shape(spr_pkg::SHAPE_OUTLINE, 0, 0, 1, 0, 0, 32'h5555_AAAA);
        run_to_end();
        // a start replaces a running command
        start_shape(spr_pkg::SHAPE_FILLED, 0, 0, 4, 4, 0, 32'h1111_1111);
        send_item(random_step());
        start_shape(spr_pkg::SHAPE_ARROW, 65535, 65535, 0, 65535, 65535, 32'h2222_2222);
        send_item(random_step());
    endtask

    // Sender holds off mid-command until every owed result has arrived.
    task automatic test_pause_midshape();
        start_shape(spr_pkg::SHAPE_FILLED, 5, 3, 5, 3, 0, 32'hCAFE_0001);
        repeat (4) send_item(random_step());
        wait_drain();
        repeat ($urandom_range(5, 20)) @(posedge clk);
        run_to_end();
    endtask

    task automatic test_random_traffic(input logic [spr_pkg::CFG_W-1:0] w,
                                       input logic [spr_pkg::CFG_W-1:0] h,
                                       input int idle_pct, input int stall_pct,
                                       input int item_count);
        wait_drain();
        set_frame(w, h);
        sender_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        items_sent = 0;
        while (items_sent < item_count)
        begin
            if ($urandom_range(99) < 12)
                send_item(random_any());
            else
                draw_random_shape();
        end
    endtask

    initial
    begin
        items_sent = 0;
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        fb_width = 0;
        fb_height = 0;
        walk_busy = 1'b0;
        walk_shape = spr_pkg::SHAPE_OUTLINE;
        org_x = 0;
        org_y = 0;
        ext_w = 0;
        ext_h = 0;
        rad = 0;
        walk_color = '0;
        row_idx = 0;
        col_idx = 0;
        vert_edges = 1'b0;
        second_half = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_frame_limits();
        test_directed_shapes();
        test_pause_midshape();
        test_random_traffic(13'd8, 13'd6, 0, 0, 490);
        test_random_traffic(13'd4096, 13'd4096, 74, 0, 490);
        test_random_traffic(13'd3, 13'h1FFF, 0, 74, 490);
        test_random_traffic(13'd20, 13'd1, 13, 13, 490);
        wait_drain();

        if (fail_count == 0)
            $display("shape_pixel_rasterizer test passed");
        else
            $display("shape_pixel_rasterizer test failed");
        $finish;
    end

endmodule
